// ----- hdl/sjpq_pkg.sv -----
// ----------------------------------------------------------------------------
// sjpq_pkg: shortest-job priority queue shared definitions
// Field widths, operation codes and result status codes of the queue.
// ----------------------------------------------------------------------------
package sjpq_pkg;

    // Fixed field widths of the stream payloads
    localparam int ID_W     = 8;
    localparam int IN_KEY_W = 16;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 5;

    typedef logic [STATUS_W-1:0] t_status;

    // Operation carried in the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam t_status STATUS_AT_HEAD = 3'd0;
    localparam t_status STATUS_BEHIND  = 3'd1;
    localparam t_status STATUS_FULL    = 3'd2;
    localparam t_status STATUS_REMOVED = 3'd3;
    localparam t_status STATUS_EMPTY   = 3'd4;

endpackage

// ----- hdl/shortest_job_priority_queue.sv -----
// ----------------------------------------------------------------------------
// shortest_job_priority_queue: sorted-insert ready queue
// Keeps up to QUEUE_DEPTH jobs in ascending key order in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the operation (insert or remove head), tdata
//   the job id and key. Each transaction yields exactly one result on the
//   output stream: status, head after the operation, removed id, occupancy.
//   An insert moves stored entries one place back, one per cycle, from the
//   tail until a key smaller or equal to the new one is met; a remove moves
//   all remaining entries up one place, one per cycle. The sequencer runs
//   one RAM read and one RAM write per cycle, so the loop over entries sets
//   the cost. A refused insert, an insert into an empty queue, an empty
//   remove and the remove of a single entry move no entries and go straight
//   to the output step. Input tready is low while an operation is in
//   progress and rises in the same cycle as the result is presented.
//   The result sits in an output register; while the receiver stalls, the
//   next transaction is still accepted and processed, and the block waits
//   before presenting it. Reset empties the queue at once; the RAM contents
//   need no clearing since only entries below the occupancy are ever used.
// ----------------------------------------------------------------------------
module shortest_job_priority_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [7:0] job_id, [23:8] job_key
    input  logic        i_s_axis_tuser,  // [0] opcode
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] status, [3] head_valid, [11:4] head_id, [27:12] head_key,
    // [35:28] removed_id, [40:36] occupancy, [47:41] zero
    output logic [47:0] o_m_axis_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = AW + 1;
    localparam int ID_W = sjpq_pkg::ID_W;
    localparam int EW = KEY_BITS + ID_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS     = 3'd1;
    localparam logic [2:0] ST_INS_PUT = 3'd2;
    localparam logic [2:0] ST_REM     = 3'd3;
    localparam logic [2:0] ST_OUT     = 3'd4;

    localparam logic [32:0] KEY_MAX = (33'd1 << KEY_BITS) - 33'd1;

    // Control state
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic          r_out_valid, n_out_valid;

    // Payload state
    logic [ID_W-1:0]         r_id, n_id;
    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [ID_W-1:0]         r_head_id, n_head_id;
    logic [KEY_BITS-1:0]     r_head_key, n_head_key;
    logic [ID_W-1:0]         r_gone, n_gone;
    sjpq_pkg::t_status       r_status, n_status;
    logic [47:0]             r_out_data, n_out_data;

    // RAM port signals
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;

    // Helpers
    logic                s_accept;
    logic [32:0]         w_key_ext;
    logic [KEY_BITS-1:0] w_key_sat;
    logic [CW-1:0]       w_cnt_m1;
    logic [KEY_BITS-1:0] w_rd_key;
    logic [ID_W-1:0]     w_rd_id;
    logic                w_full;
    logic                w_out_free;
    logic [32:0]         w_hk_ext;
    logic [8:0]          w_occ_ext;

    sjpq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Saturate the incoming key to the stored key range
    assign w_key_ext = 33'(i_s_axis_tdata[23:8]);
    assign w_key_sat = (w_key_ext > KEY_MAX) ? KEY_MAX[KEY_BITS-1:0]
                                             : w_key_ext[KEY_BITS-1:0];

    assign w_cnt_m1   = r_count - CW'(1);
    assign w_rd_key   = w_rdata[KEY_BITS-1:0];
    assign w_rd_id    = w_rdata[KEY_BITS +: ID_W];
    assign w_full     = (r_count == CW'(QUEUE_DEPTH));
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_hk_ext   = 33'(r_head_key);
    assign w_occ_ext  = 9'(r_count);

    // Sequencer: one RAM read, one RAM write and one key compare a cycle
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_id        = r_id;
        n_key       = r_key;
        n_head_id   = r_head_id;
        n_head_key  = r_head_key;
        n_gone      = r_gone;
        n_status    = r_status;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = {r_id, r_key};
        w_raddr     = r_pos;

        // Drop the result once the receiver takes it
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_id   = i_s_axis_tdata[7:0];
                    n_key  = w_key_sat;
                    n_gone = '0;
                    n_pos  = w_cnt_m1[AW-1:0];
                    if (i_s_axis_tuser == sjpq_pkg::OP_INSERT) begin
                        if (w_full) begin
                            n_status = sjpq_pkg::STATUS_FULL;
                            n_state  = ST_OUT;
                        end else if (r_count == '0) begin
                            // Empty queue: the new job is the head
                            w_we       = 1'b1;
                            w_waddr    = '0;
                            w_wdata    = {i_s_axis_tdata[7:0], w_key_sat};
                            n_head_id  = i_s_axis_tdata[7:0];
                            n_head_key = w_key_sat;
                            n_count    = CW'(1);
                            n_status   = sjpq_pkg::STATUS_AT_HEAD;
                            n_state    = ST_OUT;
                        end else begin
                            // Fetch the tail entry, free slot is at the count
                            w_raddr = w_cnt_m1[AW-1:0];
                            n_pos   = r_count[AW-1:0];
                            n_state = ST_INS;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = sjpq_pkg::STATUS_EMPTY;
                            n_state  = ST_OUT;
                        end else begin
                            n_gone   = r_head_id;
                            n_status = sjpq_pkg::STATUS_REMOVED;
                            if (r_count == CW'(1)) begin
                                n_count = '0;
                                n_state = ST_OUT;
                            end else begin
                                w_raddr = AW'(1);
                                n_pos   = AW'(1);
                                n_state = ST_REM;
                            end
                        end
                    end
                end
            end

            ST_INS: begin
                // Read data holds the entry just ahead of the free slot
                w_we    = 1'b1;
                w_waddr = r_pos;
                if (w_rd_key > r_key) begin
                    w_wdata = w_rdata;
                    n_pos   = r_pos - AW'(1);
                    w_raddr = r_pos - AW'(2);
                    if (r_pos == AW'(1)) begin
                        n_state = ST_INS_PUT;
                    end
                end else begin
                    w_wdata  = {r_id, r_key};
                    n_count  = r_count + CW'(1);
                    n_status = sjpq_pkg::STATUS_BEHIND;
                    n_state  = ST_OUT;
                end
            end

            ST_INS_PUT: begin
                // Every stored key was larger: place the job at the head
                w_we       = 1'b1;
                w_waddr    = '0;
                w_wdata    = {r_id, r_key};
                n_head_id  = r_id;
                n_head_key = r_key;
                n_count    = r_count + CW'(1);
                n_status   = sjpq_pkg::STATUS_AT_HEAD;
                n_state    = ST_OUT;
            end

            ST_REM: begin
                // Move the entry just read up one place
                w_we    = 1'b1;
                w_waddr = r_pos - AW'(1);
                w_wdata = w_rdata;
                if (r_pos == AW'(1)) begin
                    n_head_id  = w_rd_id;
                    n_head_key = w_rd_key;
                end
                if ((CW'(r_pos) + CW'(1)) == r_count) begin
                    n_count = w_cnt_m1;
                    n_state = ST_OUT;
                end else begin
                    w_raddr = r_pos + AW'(1);
                    n_pos   = r_pos + AW'(1);
                end
            end

            ST_OUT: begin
                // Load the result register when it is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data[2:0]   = r_status;
                    n_out_data[3]     = (r_count != '0);
                    n_out_data[11:4]  = (r_count != '0) ? r_head_id : '0;
                    n_out_data[27:12] = (r_count != '0) ? w_hk_ext[15:0] : '0;
                    n_out_data[35:28] = r_gone;
                    n_out_data[40:36] = w_occ_ext[4:0];
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_id       <= n_id;
        r_key      <= n_key;
        r_head_id  <= n_head_id;
        r_head_key <= n_head_key;
        r_gone     <= n_gone;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != ST_IDLE))
        else $error("sequencer did not start after a transaction");

    a_ins_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |-> ((r_pos != '0) && (CW'(r_pos) <= r_count)))
        else $error("insert slot out of range");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> (r_state == ST_OUT))
        else $error("result loaded outside the output step");

endmodule

// ----- hdl/sjpq_ram.sv -----
// ----------------------------------------------------------------------------
// sjpq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sjpq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: shortest-job priority queue stream test
// Drives insert and remove transactions into the queue, mirrors the sorted
// ready queue in a scoreboard and checks every result field by field, under
// random sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 16;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_MAX  = 20000;
    localparam int TAIL_WAIT  = 25;
    localparam int RAND_ITEMS = 150;
    localparam int MAX_PRINTS = 60;

    typedef logic [sjpq_pkg::ID_W-1:0]     t_id;
    typedef logic [sjpq_pkg::IN_KEY_W-1:0] t_key;

    // One result, laid out to match o_m_axis_tdata[40:0]
    typedef struct packed {
        logic [sjpq_pkg::OCC_W-1:0] occupancy;
        t_id                        removed_id;
        t_key                       head_key;
        t_id                        head_id;
        logic                       head_valid;
        sjpq_pkg::t_status          status;
    } t_outcome;

    // Mirror of the ready queue and the results it must produce
    class sjf_tracker;
        t_key     keys [DEPTH];
        t_id      ids  [DEPTH];
        int       count;
        t_outcome awaited [$];
        int       n_errors;

        function new();
            count    = 0;
            n_errors = 0;
        endfunction

        task report(string msg);
            if (n_errors < MAX_PRINTS)
                $display("ERROR @%0t: %s", $realtime, msg);
            n_errors++;
        endtask

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted operation and queue the outcome it must produce
        function void take_request(logic op, t_id id, t_key key);
            t_outcome r;
            int pos;
            r = '0;
            if (op == sjpq_pkg::OP_INSERT) begin
                if (count >= DEPTH) begin
                    r.status = sjpq_pkg::STATUS_FULL;
                end else begin
                    pos = count;
                    while (pos > 0 && keys[pos-1] > key) begin
                        keys[pos] = keys[pos-1];
                        ids[pos]  = ids[pos-1];
                        pos--;
                    end
                    keys[pos] = key;
                    ids[pos]  = id;
                    count++;
                    r.status = (pos == 0) ? sjpq_pkg::STATUS_AT_HEAD
                                          : sjpq_pkg::STATUS_BEHIND;
                end
            end else if (count == 0) begin
                r.status = sjpq_pkg::STATUS_EMPTY;
            end else begin
                r.removed_id = ids[0];
                for (int i = 1; i < count; i++) begin
                    keys[i-1] = keys[i];
                    ids[i-1]  = ids[i];
                end
                count--;
                r.status = sjpq_pkg::STATUS_REMOVED;
            end
            if (count > 0) begin
                r.head_valid = 1'b1;
                r.head_id    = ids[0];
                r.head_key   = keys[0];
            end
            r.occupancy = count[sjpq_pkg::OCC_W-1:0];
            awaited.push_back(r);
        endfunction

        // Compare one result transaction against the oldest expectation
        task check_response(logic [47:0] data);
            t_outcome got, want;
            got = t_outcome'(data[40:0]);
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result 0x%012h", data));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.head_valid !== want.head_valid)
                report($sformatf("head_valid got %0b want %0b",
                                 got.head_valid, want.head_valid));
            if (got.head_id !== want.head_id)
                report($sformatf("head_id got %0d want %0d", got.head_id, want.head_id));
            if (got.head_key !== want.head_key)
                report($sformatf("head_key got %0d want %0d", got.head_key, want.head_key));
            if (got.removed_id !== want.removed_id)
                report($sformatf("removed_id got %0d want %0d",
                                 got.removed_id, want.removed_id));
            if (got.occupancy !== want.occupancy)
                report($sformatf("occupancy got %0d want %0d",
                                 got.occupancy, want.occupancy));
        endtask
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [23:0] i_s_axis_tdata  = '0;   // [7:0] job_id, [23:8] job_key
    logic        i_s_axis_tuser  = 1'b0; // [0] opcode
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;         // [2:0] status .. [40:36] occupancy

    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int hold_left         = 0;
    bit hold_go           = 1'b0;

    sjf_tracker tracker;

    shortest_job_priority_queue DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Drive output tready: long hold-off on request, else random stalls
    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_left = HOLD_LEN;
            hold_go   = 1'b0;
        end
        if (hold_left > 0) begin
            i_m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            i_m_axis_tready = ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_response(o_m_axis_tdata);
    end

    // Present one operation and wait for its transaction
    task automatic send_job(input logic op, input t_id id, input t_key key);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata  = 24'($urandom);
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = op;
        i_s_axis_tdata  = {key, id};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        tracker.take_request(op, id, key);
        @(negedge i_clk);
    endtask

    // Pick a random operation; keys cluster sometimes so equal keys occur
    task automatic send_random_job(input int insert_pct);
        logic op;
        t_key key;
        int   pick;
        op   = ($urandom_range(0, 99) < insert_pct) ? sjpq_pkg::OP_INSERT
                                                    : sjpq_pkg::OP_REMOVE;
        pick = $urandom_range(0, 7);
        if (pick < 2)
            key = t_key'($urandom_range(0, 7));
        else if (pick == 2)
            key = $urandom_range(0, 1) ? '1 : '0;
        else
            key = t_key'($urandom);
        send_job(op, t_id'($urandom), key);
    endtask

    // Hold off new input until every outstanding result has come back
    task automatic wait_for_results();
        int n;
        n = 0;
        i_s_axis_tvalid = 1'b0;
        while (tracker.pending() > 0 && n < DRAIN_MAX) begin
            @(negedge i_clk);
            n++;
        end
    endtask

    initial begin
        tracker = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty remove, key extremes, equal keys, middle insert, drain
        send_job(sjpq_pkg::OP_REMOVE, 8'h5A, 16'h1234);
        send_job(sjpq_pkg::OP_INSERT, 8'h00, 16'hFFFF);
        send_job(sjpq_pkg::OP_INSERT, 8'hFF, 16'h0000);
        send_job(sjpq_pkg::OP_INSERT, 8'h01, 16'hFFFF);
        send_job(sjpq_pkg::OP_INSERT, 8'h02, 16'h0000);
        send_job(sjpq_pkg::OP_INSERT, 8'h03, 16'h8000);
        send_job(sjpq_pkg::OP_INSERT, 8'hAA, 16'h5555);
        repeat (6) send_job(sjpq_pkg::OP_REMOVE, 8'hFF, 16'hFFFF);
        send_job(sjpq_pkg::OP_REMOVE, 8'h00, 16'h0000);
        send_job(sjpq_pkg::OP_INSERT, 8'h55, 16'hAAAA);
        send_job(sjpq_pkg::OP_REMOVE, 8'h00, 16'h0000);
        wait_for_results();

        // No idling, insert-heavy so the queue fills; long output hold-off
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == 40)
                hold_go = 1'b1;
            send_random_job(75);
        end
        wait_for_results();

        // Sender gaps, remove-heavy so the queue empties
        sender_idle_pct = 52;
        for (int i = 0; i < RAND_ITEMS; i++)
            send_random_job(35);
        wait_for_results();

        // Receiver stalls, insert-heavy
        sender_idle_pct    = 0;
        receiver_stall_pct = 52;
        for (int i = 0; i < RAND_ITEMS; i++)
            send_random_job(75);
        wait_for_results();

        // Light idling on both sides, balanced
        sender_idle_pct    = 8;
        receiver_stall_pct = 8;
        for (int i = 0; i < RAND_ITEMS; i++)
            send_random_job(50);

        wait_for_results();
        if (tracker.pending() > 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (tracker.n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/sjpq_pkg.sv
hdl/sjpq_ram.sv
hdl/shortest_job_priority_queue.sv
test/testbench.sv
